[hdl/bea_pkg.sv]
// bea_pkg: shared types, codes and default sizes of the bitmap entry allocator
// no dependencies; imported by every module of the block
`default_nettype none

package bea_pkg;

    // default pool capacities and map word width
    localparam int INODE_CAPACITY_DEF = 1024;
    localparam int DATA_CAPACITY_DEF  = 16384;
    localparam int MAP_WORD_BITS_DEF  = 64;

    // field widths of the request and response
    localparam int OPCODE_W    = 2;
    localparam int INDEX_W     = 14;
    localparam int STATUS_W    = 2;
    localparam int GRANTED_W   = 14;
    localparam int FREE_LEFT_W = 15;

    // configuration port
    localparam int INODE_SIZE_W = 11;
    localparam int DATA_SIZE_W  = 15;
    localparam int CFG_DATA_W   = 15;
    localparam int CFG_INDEX_W  = 1;

    localparam logic [CFG_INDEX_W-1:0] REG_INODE_POOL_SIZE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_DATA_POOL_SIZE  = 1'b1;

    // opcodes
    localparam logic [OPCODE_W-1:0] OP_ALLOC  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_FREE   = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_FORMAT = 2'd2;

    // response status codes
    localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_INVALID = 2'd2;

    // pool select
    localparam logic POOL_INODE = 1'b0;
    localparam logic POOL_DATA  = 1'b1;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic                pool;
        logic [INDEX_W-1:0]  entry_index;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [GRANTED_W-1:0]   granted_index;
        logic [FREE_LEFT_W-1:0] free_left;
    } rsp_t;

    // per-map access control from the sequencer
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clr;
    } map_ctl_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_ALLOC_WR,
        S_SPLIT,
        S_FREE_RD,
        S_RESP
    } state_t;

endpackage

`default_nettype wire

[hdl/bitmap_entry_allocator_top.sv]
// bitmap_entry_allocator_top: first-fit allocator over an inode pool and a data block pool
// depends on bea_pkg, bea_map_ram, bea_idx_split and bea_ctrl
//
// One request is processed at a time; the response sits in an output register, so the
// next request is taken while it waits. Allocate reads map words from the pool's search
// hint up to the one holding the grant (one map word per cycle from the memory's read
// port); when the free count is zero it goes straight to the response with no map read.
// Free splits the index by a shift when MAP_WORD_BITS is a power of two; otherwise the
// index-to-word split runs a reciprocal multiply over two stages. Format, out-of-range
// frees and unused opcodes go straight to the response. Map words keep a valid bit in
// flip-flops, so reset and format clear both maps at once with no sweep.
// Pool size writes take effect at once for range checks and search, and for the free
// counts at the next format; write them only while no request is in flight.
`default_nettype none

module bitmap_entry_allocator_top #(
    parameter int INODE_CAPACITY = bea_pkg::INODE_CAPACITY_DEF,
    parameter int DATA_CAPACITY  = bea_pkg::DATA_CAPACITY_DEF,
    parameter int MAP_WORD_BITS  = bea_pkg::MAP_WORD_BITS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             req_valid,
    output logic                                  req_stall,
    input  wire bea_pkg::req_t                    req_data,
    output logic                                  rsp_valid,
    input  wire logic                             rsp_stall,
    output bea_pkg::rsp_t                         rsp_data,
    input  wire logic                             cfg_we,
    input  wire logic [bea_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [bea_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import bea_pkg::*;

    localparam int I_WORDS = (INODE_CAPACITY + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int D_WORDS = (DATA_CAPACITY + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int I_AW = (I_WORDS > 1) ? $clog2(I_WORDS) : 1;
    localparam int D_AW = (D_WORDS > 1) ? $clog2(D_WORDS) : 1;
    localparam int AW = (I_AW > D_AW) ? I_AW : D_AW;
    localparam int BW = $clog2(MAP_WORD_BITS);
    localparam int I_CW = $clog2(INODE_CAPACITY + 1);
    localparam int D_CW = $clog2(DATA_CAPACITY + 1);
    localparam int CW = (I_CW > D_CW) ? I_CW : D_CW;
    localparam int LW = (CW > DATA_SIZE_W) ? CW : DATA_SIZE_W;

    map_ctl_t                 imap_ctl;
    map_ctl_t                 dmap_ctl;
    logic [AW-1:0]            map_addr;
    logic [MAP_WORD_BITS-1:0] map_wdata;
    logic [MAP_WORD_BITS-1:0] imap_rdata;
    logic [MAP_WORD_BITS-1:0] dmap_rdata;
    logic                     split_start;
    logic [LW-1:0]            split_idx;
    logic                     split_done;
    logic [AW-1:0]            split_word;
    logic [BW-1:0]            split_bit;

    // inode used-map
    bea_map_ram #(
        .DEPTH (I_WORDS),
        .WIDTH (MAP_WORD_BITS)
    ) u_imap (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (imap_ctl),
        .addr  (map_addr[I_AW-1:0]),
        .wdata (map_wdata),
        .rdata (imap_rdata)
    );

    // data block used-map
    bea_map_ram #(
        .DEPTH (D_WORDS),
        .WIDTH (MAP_WORD_BITS)
    ) u_dmap (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (dmap_ctl),
        .addr  (map_addr[D_AW-1:0]),
        .wdata (map_wdata),
        .rdata (dmap_rdata)
    );

    // entry index to word and bit
    bea_idx_split #(
        .WORD_BITS (MAP_WORD_BITS),
        .IDX_W     (LW),
        .ADDR_W    (AW)
    ) u_split (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (split_start),
        .idx     (split_idx),
        .done    (split_done),
        .word    (split_word),
        .bit_pos (split_bit)
    );

    // sequencer and pool state
    bea_ctrl #(
        .INODE_CAPACITY (INODE_CAPACITY),
        .DATA_CAPACITY  (DATA_CAPACITY),
        .MAP_WORD_BITS  (MAP_WORD_BITS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req_data    (req_data),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp_data    (rsp_data),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .imap_ctl    (imap_ctl),
        .dmap_ctl    (dmap_ctl),
        .map_addr    (map_addr),
        .map_wdata   (map_wdata),
        .imap_rdata  (imap_rdata),
        .dmap_rdata  (dmap_rdata),
        .split_start (split_start),
        .split_idx   (split_idx),
        .split_done  (split_done),
        .split_word  (split_word),
        .split_bit   (split_bit)
    );

endmodule

`default_nettype wire

[hdl/bea_map_ram.sv]
// bea_map_ram: used-map word memory, registered read, per-word valid bits
// depends on bea_pkg (map_ctl_t); a word never written since reset or clear reads as zero
`default_nettype none

module bea_map_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire bea_pkg::map_ctl_t ctl,
    input  wire logic [AW-1:0]     addr,
    input  wire logic [WIDTH-1:0]  wdata,
    output logic [WIDTH-1:0]       rdata
);
    import bea_pkg::*;

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;
    logic [DEPTH-1:0] valid_reg;
    logic             rvalid_reg;

    // storage array and registered read
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            ram_reg[addr] <= wdata;
        end
        if (ctl.rd_en)
        begin
            rdata_reg <= ram_reg[addr];
        end
    end

    // valid bits: clear at reset and on format, set on write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.clr)
            begin
                valid_reg <= '0;
            end
            else if (ctl.wr_en)
            begin
                valid_reg[addr] <= 1'b1;
            end
            if (ctl.rd_en)
            begin
                rvalid_reg <= valid_reg[addr];
            end
        end
    end

    // stale word reads as all free
    assign rdata = rvalid_reg ? rdata_reg : '0;

endmodule

`default_nettype wire

[hdl/bea_idx_split.sv]
// bea_idx_split: splits an entry index into map word address and bit position
// depends on bea_pkg; shift for power-of-two word widths, reciprocal multiply otherwise
`default_nettype none

module bea_idx_split #(
    parameter int WORD_BITS = 64,
    parameter int IDX_W = 15,
    parameter int ADDR_W = 8,
    localparam int BW = $clog2(WORD_BITS)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [IDX_W-1:0]  idx,
    output logic                   done,
    output logic [ADDR_W-1:0]      word,
    output logic [BW-1:0]          bit_pos
);
    import bea_pkg::*;

    generate
        if ((WORD_BITS & (WORD_BITS - 1)) == 0)
        begin : g_shift
            logic              done_reg;
            logic [ADDR_W-1:0] word_reg;
            logic [BW-1:0]     bit_reg;

            // done follows start in the next cycle
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    done_reg <= 1'b0;
                end
                else
                begin
                    done_reg <= start;
                end
            end

            // word address is the upper bits, position the lower bits
            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    word_reg <= ADDR_W'(idx >> BW);
                    bit_reg  <= idx[BW-1:0];
                end
            end

            assign done    = done_reg;
            assign word    = word_reg;
            assign bit_pos = bit_reg;
        end
        else
        begin : g_recip
            // quotient by reciprocal multiply, exact for every IDX_W-bit index
            localparam int     SH    = IDX_W + BW;
            localparam int     MW    = IDX_W + 1;
            localparam longint RECIP = ((longint'(1) << SH) + longint'(WORD_BITS) - 1) /
                                       longint'(WORD_BITS);

            logic              stage_reg;
            logic              done_reg;
            logic [IDX_W-1:0]  idx_reg;
            logic [ADDR_W-1:0] quo_reg;
            logic [BW-1:0]     bit_reg;
            logic [IDX_W+MW-1:0] prod;
            logic [ADDR_W-1:0] quo;
            logic [BW-1:0]     low_prod;
            logic [BW-1:0]     rem;

            // first stage quotient, second stage remainder from the low bits only
            always_comb
            begin
                prod     = idx * MW'(RECIP);
                quo      = ADDR_W'(prod >> SH);
                low_prod = BW'(quo_reg) * BW'(WORD_BITS);
                rem      = idx_reg[BW-1:0] - low_prod;
            end

            // done follows start through stage_reg and then done_reg
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    stage_reg <= 1'b0;
                    done_reg  <= 1'b0;
                end
                else
                begin
                    stage_reg <= start;
                    done_reg  <= stage_reg;
                end
            end

            // quotient and remainder registers
            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    idx_reg <= idx;
                    quo_reg <= quo;
                end
                if (stage_reg)
                begin
                    bit_reg <= rem;
                end
            end

            assign done    = done_reg;
            assign word    = quo_reg;
            assign bit_pos = bit_reg;
        end
    endgenerate

endmodule

`default_nettype wire

[hdl/bea_ctrl.sv]
// bea_ctrl: request sequencer, pool counters, search hints, size registers and response register
// depends on bea_pkg; drives the two map memories and the index splitter
`default_nettype none

module bea_ctrl #(
    parameter int INODE_CAPACITY = bea_pkg::INODE_CAPACITY_DEF,
    parameter int DATA_CAPACITY  = bea_pkg::DATA_CAPACITY_DEF,
    parameter int MAP_WORD_BITS  = bea_pkg::MAP_WORD_BITS_DEF,
    localparam int I_WORDS = (INODE_CAPACITY + MAP_WORD_BITS - 1) / MAP_WORD_BITS,
    localparam int D_WORDS = (DATA_CAPACITY + MAP_WORD_BITS - 1) / MAP_WORD_BITS,
    localparam int I_AW = (I_WORDS > 1) ? $clog2(I_WORDS) : 1,
    localparam int D_AW = (D_WORDS > 1) ? $clog2(D_WORDS) : 1,
    localparam int AW = (I_AW > D_AW) ? I_AW : D_AW,
    localparam int BW = $clog2(MAP_WORD_BITS),
    localparam int I_CW = $clog2(INODE_CAPACITY + 1),
    localparam int D_CW = $clog2(DATA_CAPACITY + 1),
    localparam int CW = (I_CW > D_CW) ? I_CW : D_CW,
    localparam int LW = (CW > bea_pkg::DATA_SIZE_W) ? CW : bea_pkg::DATA_SIZE_W
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             req_valid,
    output logic                                  req_stall,
    input  wire bea_pkg::req_t                    req_data,
    output logic                                  rsp_valid,
    input  wire logic                             rsp_stall,
    output bea_pkg::rsp_t                         rsp_data,
    input  wire logic                             cfg_we,
    input  wire logic [bea_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [bea_pkg::CFG_DATA_W-1:0]   cfg_data,
    output bea_pkg::map_ctl_t                     imap_ctl,
    output bea_pkg::map_ctl_t                     dmap_ctl,
    output logic [AW-1:0]                         map_addr,
    output logic [MAP_WORD_BITS-1:0]              map_wdata,
    input  wire logic [MAP_WORD_BITS-1:0]         imap_rdata,
    input  wire logic [MAP_WORD_BITS-1:0]         dmap_rdata,
    output logic                                  split_start,
    output logic [LW-1:0]                         split_idx,
    input  wire logic                             split_done,
    input  wire logic [AW-1:0]                    split_word,
    input  wire logic [BW-1:0]                    split_bit
);
    import bea_pkg::*;

    state_t state_reg, state_next;

    logic                     pool_reg, pool_next;
    logic [AW-1:0]            word_reg, word_next;
    logic [LW-1:0]            base_reg, base_next;
    logic [BW-1:0]            bit_reg, bit_next;
    logic [MAP_WORD_BITS-1:0] wdata_reg, wdata_next;
    logic [STATUS_W-1:0]      status_reg, status_next;
    logic [LW-1:0]            granted_reg, granted_next;
    logic [I_CW-1:0]          icnt_reg, icnt_next;
    logic [D_CW-1:0]          dcnt_reg, dcnt_next;
    logic [I_AW-1:0]          ihint_reg, ihint_next;
    logic [D_AW-1:0]          dhint_reg, dhint_next;
    logic [I_CW-1:0]          isize_reg, isize_next;
    logic [D_CW-1:0]          dsize_reg, dsize_next;
    logic                     rsp_valid_reg, rsp_valid_next;
    rsp_t                     rsp_data_reg, rsp_data_next;

    logic                     accept;
    logic                     sel_pool;
    logic [LW-1:0]            size_sel;
    logic [LW-1:0]            cnt_sel;
    logic [AW-1:0]            hint_sel;
    logic [MAP_WORD_BITS-1:0] rdata;
    logic [LW-1:0]            lim;
    logic                     in_range_any;
    logic [MAP_WORD_BITS-1:0] avail;
    logic                     found;
    logic [BW-1:0]            found_bit;
    logic                     last_word;
    logic [MAP_WORD_BITS-1:0] bit_mask;
    logic [LW-1:0]            cfg_ival;
    logic [LW-1:0]            cfg_dval;

    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;
    assign split_idx = LW'(req_data.entry_index);

    // pool-selected views of the state
    always_comb
    begin
        sel_pool = (state_reg == S_IDLE) ? req_data.pool : pool_reg;
        size_sel = (sel_pool == POOL_DATA) ? LW'(dsize_reg) : LW'(isize_reg);
        cnt_sel  = (sel_pool == POOL_DATA) ? LW'(dcnt_reg) : LW'(icnt_reg);
        hint_sel = (sel_pool == POOL_DATA) ? AW'(dhint_reg) : AW'(ihint_reg);
        rdata    = (pool_reg == POOL_DATA) ? dmap_rdata : imap_rdata;
        bit_mask = MAP_WORD_BITS'(1) << bit_reg;
    end

    // first-fit search in the word just read, out-of-range bits count as used
    always_comb
    begin
        in_range_any = base_reg < size_sel;
        lim          = size_sel - base_reg;
        for (int j = 0; j < MAP_WORD_BITS; j++)
        begin
            avail[j] = !rdata[j] && in_range_any && (LW'(j) < lim);
        end
        found_bit = '0;
        for (int j = MAP_WORD_BITS - 1; j >= 0; j--)
        begin
            if (avail[j])
            begin
                found_bit = BW'(j);
            end
        end
        found     = |avail;
        last_word = ({1'b0, base_reg} + (LW+1)'(MAP_WORD_BITS)) >= {1'b0, size_sel};
    end

    // written pool size fields, widened for the clamp to the capacities
    always_comb
    begin
        cfg_ival = LW'(cfg_data[INODE_SIZE_W-1:0]);
        cfg_dval = LW'(cfg_data[DATA_SIZE_W-1:0]);
    end

    // next state and datapath control
    always_comb
    begin
        state_next     = state_reg;
        pool_next      = pool_reg;
        word_next      = word_reg;
        base_next      = base_reg;
        bit_next       = bit_reg;
        wdata_next     = wdata_reg;
        status_next    = status_reg;
        granted_next   = granted_reg;
        icnt_next      = icnt_reg;
        dcnt_next      = dcnt_reg;
        ihint_next     = ihint_reg;
        dhint_next     = dhint_reg;
        isize_next     = isize_reg;
        dsize_next     = dsize_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_data_next  = rsp_data_reg;
        imap_ctl       = '0;
        dmap_ctl       = '0;
        map_addr       = word_reg;
        map_wdata      = wdata_reg;
        split_start    = 1'b0;

        // configuration writes, only while idle: the user must keep to this, the block does not enforce it
        if (cfg_we)
        begin
            if (cfg_index == REG_INODE_POOL_SIZE)
            begin
                isize_next = (cfg_ival > LW'(INODE_CAPACITY)) ?
                             I_CW'(INODE_CAPACITY) : cfg_ival[I_CW-1:0];
            end
            else if (cfg_index == REG_DATA_POOL_SIZE)
            begin
                dsize_next = (cfg_dval > LW'(DATA_CAPACITY)) ?
                             D_CW'(DATA_CAPACITY) : cfg_dval[D_CW-1:0];
            end
        end

        // response taken downstream
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    pool_next    = req_data.pool;
                    granted_next = '0;
                    case (req_data.opcode)
                        OP_ALLOC:
                        begin
                            if (cnt_sel == '0)
                            begin
                                status_next = STAT_FULL;
                                state_next  = S_RESP;
                            end
                            else
                            begin
                                // first read at the hint word
                                map_addr  = hint_sel;
                                word_next = hint_sel;
                                base_next = LW'(hint_sel) * LW'(MAP_WORD_BITS);
                                if (req_data.pool == POOL_DATA)
                                begin
                                    dmap_ctl.rd_en = 1'b1;
                                end
                                else
                                begin
                                    imap_ctl.rd_en = 1'b1;
                                end
                                state_next = S_SCAN;
                            end
                        end
                        OP_FREE:
                        begin
                            if (LW'(req_data.entry_index) >= size_sel)
                            begin
                                status_next = STAT_INVALID;
                                state_next  = S_RESP;
                            end
                            else
                            begin
                                split_start = 1'b1;
                                state_next  = S_SPLIT;
                            end
                        end
                        OP_FORMAT:
                        begin
                            imap_ctl.clr = 1'b1;
                            dmap_ctl.clr = 1'b1;
                            icnt_next    = isize_reg;
                            dcnt_next    = dsize_reg;
                            ihint_next   = '0;
                            dhint_next   = '0;
                            status_next  = STAT_OK;
                            state_next   = S_RESP;
                        end
                        default:
                        begin
                            status_next = STAT_INVALID;
                            state_next  = S_RESP;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                if (found)
                begin
                    wdata_next   = rdata | (MAP_WORD_BITS'(1) << found_bit);
                    granted_next = base_reg + LW'(found_bit);
                    state_next   = S_ALLOC_WR;
                end
                else if (last_word)
                begin
                    status_next = STAT_FULL;
                    state_next  = S_RESP;
                end
                else
                begin
                    // move on, next word read issued now
                    word_next = word_reg + AW'(1);
                    base_next = base_reg + LW'(MAP_WORD_BITS);
                    map_addr  = word_reg + AW'(1);
                    if (pool_reg == POOL_DATA)
                    begin
                        dmap_ctl.rd_en = 1'b1;
                    end
                    else
                    begin
                        imap_ctl.rd_en = 1'b1;
                    end
                end
            end

            S_ALLOC_WR:
            begin
                map_addr  = word_reg;
                map_wdata = wdata_reg;
                if (pool_reg == POOL_DATA)
                begin
                    dmap_ctl.wr_en = 1'b1;
                    dcnt_next      = dcnt_reg - D_CW'(1);
                    dhint_next     = word_reg[D_AW-1:0];
                end
                else
                begin
                    imap_ctl.wr_en = 1'b1;
                    icnt_next      = icnt_reg - I_CW'(1);
                    ihint_next     = word_reg[I_AW-1:0];
                end
                status_next = STAT_OK;
                state_next  = S_RESP;
            end

            S_SPLIT:
            begin
                if (split_done)
                begin
                    word_next = split_word;
                    bit_next  = split_bit;
                    map_addr  = split_word;
                    if (pool_reg == POOL_DATA)
                    begin
                        dmap_ctl.rd_en = 1'b1;
                    end
                    else
                    begin
                        imap_ctl.rd_en = 1'b1;
                    end
                    state_next = S_FREE_RD;
                end
            end

            S_FREE_RD:
            begin
                if ((rdata & bit_mask) == '0)
                begin
                    // double free
                    status_next = STAT_INVALID;
                end
                else
                begin
                    map_addr  = word_reg;
                    map_wdata = rdata & ~bit_mask;
                    if (pool_reg == POOL_DATA)
                    begin
                        dmap_ctl.wr_en = 1'b1;
                        if (dcnt_reg < D_CW'(DATA_CAPACITY))
                        begin
                            dcnt_next = dcnt_reg + D_CW'(1);
                        end
                        if (word_reg < AW'(dhint_reg))
                        begin
                            dhint_next = word_reg[D_AW-1:0];
                        end
                    end
                    else
                    begin
                        imap_ctl.wr_en = 1'b1;
                        if (icnt_reg < I_CW'(INODE_CAPACITY))
                        begin
                            icnt_next = icnt_reg + I_CW'(1);
                        end
                        if (word_reg < AW'(ihint_reg))
                        begin
                            ihint_next = word_reg[I_AW-1:0];
                        end
                    end
                    status_next = STAT_OK;
                end
                state_next = S_RESP;
            end

            S_RESP:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next              = 1'b1;
                    rsp_data_next.status        = status_reg;
                    rsp_data_next.granted_index = granted_reg[GRANTED_W-1:0];
                    rsp_data_next.free_left     = cnt_sel[FREE_LEFT_W-1:0];
                    state_next                  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            icnt_reg      <= I_CW'(INODE_CAPACITY);
            dcnt_reg      <= D_CW'(DATA_CAPACITY);
            ihint_reg     <= '0;
            dhint_reg     <= '0;
            isize_reg     <= I_CW'(INODE_CAPACITY);
            dsize_reg     <= D_CW'(DATA_CAPACITY);
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            icnt_reg      <= icnt_next;
            dcnt_reg      <= dcnt_next;
            ihint_reg     <= ihint_next;
            dhint_reg     <= dhint_next;
            isize_reg     <= isize_next;
            dsize_reg     <= dsize_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pool_reg     <= pool_next;
        word_reg     <= word_next;
        base_reg     <= base_next;
        bit_reg      <= bit_next;
        wdata_reg    <= wdata_next;
        status_reg   <= status_next;
        granted_reg  <= granted_next;
        rsp_data_reg <= rsp_data_next;
    end

endmodule

`default_nettype wire

[hdl/bea_checker.sv]
// bea_checker: port-level assertions for the bitmap entry allocator
// depends on bea_pkg; bound to bitmap_entry_allocator_top at the end of this file
`default_nettype none

module bea_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             req_valid,
    input wire logic                             req_stall,
    input wire bea_pkg::req_t                    req_data,
    input wire logic                             rsp_valid,
    input wire logic                             rsp_stall,
    input wire bea_pkg::rsp_t                    rsp_data,
    input wire logic                             cfg_we,
    input wire logic [bea_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input wire logic [bea_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import bea_pkg::*;

    // one request in flight: the cycle after a request is taken the input stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("request taken while previous one still in flight");

    // a failed request never grants an index
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp_data.status != STAT_OK)) |-> (rsp_data.granted_index == '0))
        else $error("granted index nonzero on failed request");

    // a fresh response is only produced while the input side is busy
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_stall))
        else $error("response appeared without a request in progress");

    // a stalled response holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
        else $error("stalled response changed");

endmodule

bind bitmap_entry_allocator_top bea_checker u_bea_checker (.*);

`default_nettype wire
